// File: hw/rtl/iba_pkg.sv
// Shared types and constants for the indexed block allocator.
`timescale 1ns / 1ps
package iba_pkg;

  localparam int NUM_BLOCKS_DEF = 16;
  localparam int MAX_FILES_DEF  = 10;
  localparam int MAX_DATA       = 16;
  localparam int MASK_BITS      = 16;
  localparam logic [MASK_BITS-1:0] MASK_RESET = 16'd2308;

  typedef enum logic [0:0] {
    CMD_ALLOC  = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_NO_SPACE   = 3'd1,
    STS_NO_INDEX   = 3'd2,
    STS_DIR_FULL   = 3'd3,
    STS_ZERO_SIZE  = 3'd4,
    STS_NO_FILE    = 3'd5
  } status_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  file_name;
    logic [4:0]  file_size;
    logic [3:0]  file_slot;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  block_number;
    logic        is_index;
    logic [3:0]  dir_slot;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_BUILD,
    ST_IDLE,
    ST_CHECK,
    ST_AWALK,
    ST_AIDX,
    ST_DENT,
    ST_DWALK,
    ST_CMP_RD,
    ST_CMP_WR
  } state_t;

endpackage

// File: hw/rtl/iba_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module iba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/iba_idx_find.sv
// Finds the lowest index block that is not in use.
`timescale 1ns / 1ps
module iba_idx_find #(
  parameter int NUM_BLOCKS = iba_pkg::NUM_BLOCKS_DEF
) (
  input  logic [iba_pkg::MASK_BITS-1:0]   mask,
  input  logic [NUM_BLOCKS-1:0]           used,
  output logic                            found,
  output logic [$clog2(NUM_BLOCKS)-1:0]   idx
);

  localparam int BW  = $clog2(NUM_BLOCKS);
  localparam int LIM = (NUM_BLOCKS < iba_pkg::MASK_BITS) ? NUM_BLOCKS : iba_pkg::MASK_BITS;

  // scan from the top down so the lowest hit wins
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int b = LIM - 1; b >= 0; b--) begin
      if (mask[b] && !used[b]) begin
        found = 1'b1;
        idx   = BW'(b);
      end
    end
  end

endmodule

// File: hw/rtl/indexed_block_allocator.sv
// Top level of the indexed block allocator: sequencer, link RAM and directory RAM.
`timescale 1ns / 1ps
//
//  channel  | ports                        | beat taken at edge where
//  ---------+------------------------------+--------------------------
//  input    | start, busy, in_item         | start & !busy
//  result   | out_valid, out_item          | out_valid (one cycle, no stall)
//  config   | cfg_we, cfg_wdata            | cfg_we
//
//  Sequence: allocate holds busy through a check state, one walk step per data block
//  read through the next-link RAM and one step for the index block; rejects end after
//  the check. Delete runs check, directory read and chain walk, plus, when files sit
//  above the slot, compaction of the directory RAM, one write step per such file.
//  The link walk moves on by one block per RAM read.
//  Reset and every config write start a rebuild pass over the link RAM, one step per
//  block, with busy high. Results leave through one register stage.
//
module indexed_block_allocator #(
  parameter int NUM_BLOCKS = iba_pkg::NUM_BLOCKS_DEF,
  parameter int MAX_FILES  = iba_pkg::MAX_FILES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  iba_pkg::in_item_t             in_item,
  output logic                          out_valid,
  output iba_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [iba_pkg::MASK_BITS-1:0] cfg_wdata
);

  localparam int BW  = $clog2(NUM_BLOCKS);
  localparam int DAW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int DCW = $clog2(MAX_FILES + 1);
  localparam int FCW = $clog2(NUM_BLOCKS + 1);
  localparam int DEW = 8 + 3 * BW;   // name, index block, first, last

  // control state
  iba_pkg::state_t                 state_r, state_nxt;
  logic [iba_pkg::MASK_BITS-1:0]   mask_r, mask_nxt;
  logic [BW:0]                     b_r, b_nxt;            // rebuild sweep
  logic                            prev_vld_r, prev_vld_nxt;
  logic [FCW-1:0]                  fc_r, fc_nxt;          // free count
  logic [BW-1:0]                   head_r, head_nxt;      // free chain head
  logic [DCW-1:0]                  dc_r, dc_nxt;          // directory fill
  logic [NUM_BLOCKS-1:0]           used_r, used_nxt;      // block busy bits
  logic                            out_valid_r, out_valid_nxt;

  // payload / working registers
  iba_pkg::in_item_t               item_r, item_nxt;
  iba_pkg::out_item_t              out_item_r, out_item_nxt;
  logic [BW-1:0]                   prev_r, prev_nxt;
  logic [BW-1:0]                   idx_r, idx_nxt;
  logic [4:0]                      k_r, k_nxt;
  logic                            first_r, first_nxt;
  logic [BW-1:0]                   cur_r, cur_nxt;
  logic [BW-1:0]                   ent_first_r, ent_first_nxt;
  logic [BW-1:0]                   ent_last_r, ent_last_nxt;
  logic [BW-1:0]                   ent_idx_r, ent_idx_nxt;
  logic [BW:0]                     n_r, n_nxt;
  logic [DAW-1:0]                  cmp_k_r, cmp_k_nxt;

  // RAM ports
  logic            lk_we;
  logic [BW-1:0]   lk_waddr, lk_wdata, lk_raddr, lk_rdata;
  logic            dr_we;
  logic [DAW-1:0]  dr_waddr, dr_raddr;
  logic [DEW-1:0]  dr_wdata, dr_rdata;

  // index block finder
  logic            fnd_found;
  logic [BW-1:0]   fnd_idx;

  // decode helpers
  logic [7:0]      size8, fc8, dc8, slot8, b8, sum8;
  logic            rej_zero, rej_full, rej_space;
  logic            del_bad, del_compact;
  logic [BW-1:0]   aw_cur, dw_cur;
  logic            aw_done, dw_more, b_end, cmp_more, b_is_idx;

  function automatic logic [3:0] blk4(input logic [BW-1:0] b);
    logic [BW+3:0] t;
    t = {4'b0, b};
    return t[3:0];
  endfunction

  iba_ram #(.WIDTH(BW), .DEPTH(NUM_BLOCKS)) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  iba_ram #(.WIDTH(DEW), .DEPTH(MAX_FILES)) u_dir_ram (
    .clk   (clk),
    .we    (dr_we),
    .waddr (dr_waddr),
    .wdata (dr_wdata),
    .raddr (dr_raddr),
    .rdata (dr_rdata)
  );

  iba_idx_find #(.NUM_BLOCKS(NUM_BLOCKS)) u_idx_find (
    .mask  (mask_r),
    .used  (used_r),
    .found (fnd_found),
    .idx   (fnd_idx)
  );

  assign busy      = (state_r != iba_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign size8 = {3'b000, item_r.file_size};
  assign fc8   = 8'(fc_r);
  assign dc8   = 8'(dc_r);
  assign slot8 = {4'b0000, item_r.file_slot};
  assign b8    = 8'(b_r);
  assign sum8  = fc8 + 8'(n_r);

  assign rej_zero    = (item_r.file_size == 5'd0);
  assign rej_full    = (dc_r >= DCW'(MAX_FILES));
  assign rej_space   = (size8 > fc8) || (size8 > 8'(iba_pkg::MAX_DATA));
  assign del_bad     = (slot8 >= dc8);
  assign del_compact = ((slot8 + 8'd1) < dc8);

  // first step of a walk starts from a register, later steps from the link RAM
  assign aw_cur   = first_r ? head_r : lk_rdata;
  assign dw_cur   = first_r ? ent_first_r : lk_rdata;
  assign aw_done  = ((k_r + 5'd1) == item_r.file_size);
  assign dw_more  = (dw_cur != ent_last_r) && (n_r < (BW+1)'(NUM_BLOCKS));
  assign b_end    = (b_r == (BW+1)'(NUM_BLOCKS));
  assign cmp_more = ((8'(cmp_k_r) + 8'd1) < dc8);
  assign b_is_idx = (b8 < 8'(iba_pkg::MASK_BITS)) && mask_r[b8[3:0]];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      iba_pkg::ST_BUILD: begin
        if (b_end) state_nxt = iba_pkg::ST_IDLE;
      end
      iba_pkg::ST_IDLE: begin
        if (start) state_nxt = iba_pkg::ST_CHECK;
      end
      iba_pkg::ST_CHECK: begin
        if (item_r.cmd == iba_pkg::CMD_ALLOC) begin
          if (rej_zero || rej_full || rej_space || !fnd_found) state_nxt = iba_pkg::ST_IDLE;
          else state_nxt = iba_pkg::ST_AWALK;
        end else begin
          if (del_bad) state_nxt = iba_pkg::ST_IDLE;
          else state_nxt = iba_pkg::ST_DENT;
        end
      end
      iba_pkg::ST_AWALK: begin
        if (aw_done) state_nxt = iba_pkg::ST_AIDX;
      end
      iba_pkg::ST_AIDX: state_nxt = iba_pkg::ST_IDLE;
      iba_pkg::ST_DENT: state_nxt = iba_pkg::ST_DWALK;
      iba_pkg::ST_DWALK: begin
        if (!dw_more) state_nxt = del_compact ? iba_pkg::ST_CMP_RD : iba_pkg::ST_IDLE;
      end
      iba_pkg::ST_CMP_RD: state_nxt = iba_pkg::ST_CMP_WR;
      iba_pkg::ST_CMP_WR: begin
        if (!cmp_more) state_nxt = iba_pkg::ST_IDLE;
      end
      default: state_nxt = iba_pkg::ST_IDLE;
    endcase
    if (cfg_we) state_nxt = iba_pkg::ST_BUILD;
  end

  // datapath, RAM strobes and result beat
  always_comb begin
    mask_nxt      = mask_r;
    b_nxt         = b_r;
    prev_vld_nxt  = prev_vld_r;
    prev_nxt      = prev_r;
    fc_nxt        = fc_r;
    head_nxt      = head_r;
    dc_nxt        = dc_r;
    used_nxt      = used_r;
    item_nxt      = item_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    first_nxt     = first_r;
    cur_nxt       = cur_r;
    ent_first_nxt = ent_first_r;
    ent_last_nxt  = ent_last_r;
    ent_idx_nxt   = ent_idx_r;
    n_nxt         = n_r;
    cmp_k_nxt     = cmp_k_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    lk_we         = 1'b0;
    lk_waddr      = '0;
    lk_wdata      = '0;
    lk_raddr      = '0;
    dr_we         = 1'b0;
    dr_waddr      = '0;
    dr_wdata      = '0;
    dr_raddr      = '0;

    case (state_r)
      iba_pkg::ST_BUILD: begin
        if (!b_end) begin
          if (!b_is_idx) begin
            // data block: link it behind the previous one
            if (prev_vld_r) begin
              lk_we    = 1'b1;
              lk_waddr = prev_r;
              lk_wdata = b_r[BW-1:0];
            end else begin
              head_nxt = b_r[BW-1:0];
            end
            prev_nxt     = b_r[BW-1:0];
            prev_vld_nxt = 1'b1;
            fc_nxt       = fc_r + FCW'(1);
          end else begin
            lk_we    = 1'b1;
            lk_waddr = b_r[BW-1:0];
          end
          b_nxt = b_r + (BW+1)'(1);
        end else if (prev_vld_r) begin
          lk_we    = 1'b1;   // chain tail points at zero
          lk_waddr = prev_r;
        end
      end

      iba_pkg::ST_IDLE: begin
        if (start) item_nxt = in_item;
      end

      iba_pkg::ST_CHECK: begin
        out_item_nxt.block_number = 4'd0;
        out_item_nxt.is_index     = 1'b0;
        out_item_nxt.dir_slot     = 4'd0;
        out_item_nxt.last         = 1'b1;
        if (item_r.cmd == iba_pkg::CMD_ALLOC) begin
          idx_nxt   = fnd_idx;
          k_nxt     = 5'd0;
          first_nxt = 1'b1;
          out_valid_nxt = rej_zero || rej_full || rej_space || !fnd_found;
          if (rej_zero)       out_item_nxt.status = iba_pkg::STS_ZERO_SIZE;
          else if (rej_full)  out_item_nxt.status = iba_pkg::STS_DIR_FULL;
          else if (rej_space) out_item_nxt.status = iba_pkg::STS_NO_SPACE;
          else                out_item_nxt.status = iba_pkg::STS_NO_INDEX;
        end else begin
          dr_raddr            = slot8[DAW-1:0];
          out_valid_nxt       = del_bad;
          out_item_nxt.status = iba_pkg::STS_NO_FILE;
        end
      end

      iba_pkg::ST_AWALK: begin
        lk_raddr         = aw_cur;
        used_nxt[aw_cur] = 1'b1;
        cur_nxt          = aw_cur;
        k_nxt            = k_r + 5'd1;
        first_nxt        = 1'b0;
        out_valid_nxt             = 1'b1;
        out_item_nxt.status       = iba_pkg::STS_OK;
        out_item_nxt.block_number = blk4(aw_cur);
        out_item_nxt.is_index     = 1'b0;
        out_item_nxt.dir_slot     = dc8[3:0];
        out_item_nxt.last         = 1'b0;
      end

      iba_pkg::ST_AIDX: begin
        fc_nxt        = fc_r - size8[FCW-1:0];
        head_nxt      = (fc8 != size8) ? lk_rdata : '0;
        used_nxt[idx_r] = 1'b1;
        dr_we         = 1'b1;
        dr_waddr      = dc8[DAW-1:0];
        dr_wdata      = {item_r.file_name, idx_r, head_r, cur_r};
        dc_nxt        = dc_r + DCW'(1);
        out_valid_nxt             = 1'b1;
        out_item_nxt.status       = iba_pkg::STS_OK;
        out_item_nxt.block_number = blk4(idx_r);
        out_item_nxt.is_index     = 1'b1;
        out_item_nxt.dir_slot     = dc8[3:0];
        out_item_nxt.last         = 1'b1;
      end

      iba_pkg::ST_DENT: begin
        ent_first_nxt = dr_rdata[2*BW-1 -: BW];
        ent_last_nxt  = dr_rdata[BW-1:0];
        ent_idx_nxt   = dr_rdata[3*BW-1 -: BW];
        first_nxt     = 1'b1;
        n_nxt         = (BW+1)'(1);
      end

      iba_pkg::ST_DWALK: begin
        used_nxt[dw_cur] = 1'b0;
        first_nxt        = 1'b0;
        if (dw_more) begin
          lk_raddr = dw_cur;
          n_nxt    = n_r + (BW+1)'(1);
        end else begin
          // splice the freed chain in front of the free list
          lk_we    = 1'b1;
          lk_waddr = dw_cur;
          lk_wdata = (fc_r != '0) ? head_r : '0;
          head_nxt = ent_first_r;
          fc_nxt   = (sum8 > 8'(NUM_BLOCKS)) ? FCW'(NUM_BLOCKS) : sum8[FCW-1:0];
          used_nxt[ent_idx_r] = 1'b0;
          dc_nxt    = dc_r - DCW'(1);
          cmp_k_nxt = slot8[DAW-1:0];
          out_valid_nxt             = 1'b1;
          out_item_nxt.status       = iba_pkg::STS_OK;
          out_item_nxt.block_number = blk4(ent_idx_r);
          out_item_nxt.is_index     = 1'b1;
          out_item_nxt.dir_slot     = item_r.file_slot;
          out_item_nxt.last         = 1'b1;
        end
      end

      iba_pkg::ST_CMP_RD: begin
        dr_raddr = cmp_k_r + DAW'(1);
      end

      iba_pkg::ST_CMP_WR: begin
        dr_we    = 1'b1;
        dr_waddr = cmp_k_r;
        dr_wdata = dr_rdata;
        if (cmp_more) begin
          cmp_k_nxt = cmp_k_r + DAW'(1);
          dr_raddr  = cmp_k_r + DAW'(2);
        end
      end

      default: ;
    endcase

    // register write restarts the rebuild pass
    if (cfg_we) begin
      mask_nxt     = cfg_wdata;
      b_nxt        = '0;
      prev_vld_nxt = 1'b0;
      fc_nxt       = '0;
      head_nxt     = '0;
      dc_nxt       = '0;
      used_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iba_pkg::ST_BUILD;
      mask_r      <= iba_pkg::MASK_RESET;
      b_r         <= '0;
      prev_vld_r  <= 1'b0;
      fc_r        <= '0;
      head_r      <= '0;
      dc_r        <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      b_r         <= b_nxt;
      prev_vld_r  <= prev_vld_nxt;
      fc_r        <= fc_nxt;
      head_r      <= head_nxt;
      dc_r        <= dc_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    out_item_r  <= out_item_nxt;
    prev_r      <= prev_nxt;
    idx_r       <= idx_nxt;
    k_r         <= k_nxt;
    first_r     <= first_nxt;
    cur_r       <= cur_nxt;
    ent_first_r <= ent_first_nxt;
    ent_last_r  <= ent_last_nxt;
    ent_idx_r   <= ent_idx_nxt;
    n_r         <= n_nxt;
    cmp_k_r     <= cmp_k_nxt;
  end

`ifndef NO_ASSERTIONS
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !cfg_we) |=> (state_r == iba_pkg::ST_CHECK))
    else $error("accepted beat did not enter check");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last && $past(rst_n) && !$past(cfg_we)) |->
      (state_r == iba_pkg::ST_IDLE || state_r == iba_pkg::ST_CMP_RD))
    else $error("final result beat while item still in progress");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == iba_pkg::ST_AWALK) |-> (k_r < item_r.file_size))
    else $error("allocate walk ran past file size");

  a_count_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (fc_r <= FCW'(NUM_BLOCKS)) && (dc_r <= DCW'(MAX_FILES)))
    else $error("free count or directory count out of range");

  a_quiet_build: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == iba_pkg::ST_BUILD && $past(state_r) == iba_pkg::ST_BUILD) |-> !out_valid)
    else $error("result beat during rebuild");
`endif

endmodule

// File: tb/sv/iba_tb_pkg.sv
// Free-list and directory tracker for checking the indexed block allocator.
`timescale 1ns / 1ps
package iba_tb_pkg;
  import iba_pkg::*;

  class free_list_tracker;
    logic [15:0] mask;
    logic [4:0]  next_link [16];
    bit          taken [16];
    logic [4:0]  free_head;
    logic [4:0]  free_count;
    logic [7:0]  dir_name [MAX_FILES_DEF];
    logic [3:0]  dir_index [MAX_FILES_DEF];
    logic [3:0]  dir_first [MAX_FILES_DEF];
    logic [3:0]  dir_last [MAX_FILES_DEF];
    logic [3:0]  dir_count;
    out_item_t   owed_results [$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    function int clamp(int b);
      return (b < NUM_BLOCKS_DEF) ? b : 0;
    endfunction

    // Config write: chain, busy bits and directory go back to their reset form.
    function void load_mask(logic [15:0] m);
      int prev;
      prev = -1;
      mask = m;
      dir_count = '0;
      free_head = '0;
      free_count = '0;
      for (int k = 0; k < MAX_FILES_DEF; k++) begin
        dir_name[k] = '0;
        dir_index[k] = '0;
        dir_first[k] = '0;
        dir_last[k] = '0;
      end
      for (int b = 0; b < NUM_BLOCKS_DEF; b++) begin
        next_link[b] = '0;
        taken[b] = 1'b0;
      end
      for (int b = 0; b < NUM_BLOCKS_DEF; b++) begin
        if (!m[b]) begin
          if (prev < 0) free_head = 5'(b);
          else next_link[prev] = 5'(b);
          prev = b;
          free_count++;
        end
      end
    endfunction

    function void owe(status_t st, int blk, bit idx, int slot, bit lst);
      out_item_t r;
      r.status = st;
      r.block_number = 4'(blk);
      r.is_index = idx;
      r.dir_slot = 4'(slot);
      r.last = lst;
      owed_results.push_back(r);
    endfunction

    // Accepted command: update the disk picture and queue the beats it owes.
    function void apply_command(in_item_t it);
      int size, slot, cur, idx, n, total, dc;
      bit found;
      size = it.file_size;
      slot = it.file_slot;
      dc = dir_count;
      found = 1'b0;
      idx = 0;
      if (it.cmd == CMD_ALLOC) begin
        if (size == 0) begin
          owe(STS_ZERO_SIZE, 0, 0, 0, 1);
          return;
        end
        if (dc >= MAX_FILES_DEF) begin
          owe(STS_DIR_FULL, 0, 0, 0, 1);
          return;
        end
        if (size > free_count || size > MAX_DATA) begin
          owe(STS_NO_SPACE, 0, 0, 0, 1);
          return;
        end
        for (int b = 0; b < NUM_BLOCKS_DEF; b++) begin
          if (!found && mask[b] && !taken[b]) begin
            idx = b;
            found = 1'b1;
          end
        end
        if (!found) begin
          owe(STS_NO_INDEX, 0, 0, 0, 1);
          return;
        end
        cur = clamp(free_head);
        dir_first[dc] = 4'(cur);
        for (int k = 0; k < size; k++) begin
          taken[cur] = 1'b1;
          owe(STS_OK, cur, 0, dc, 0);
          dir_last[dc] = 4'(cur);
          if (k + 1 < size) cur = clamp(next_link[cur]);
        end
        free_count = 5'(free_count - size);
        free_head = (free_count != 0) ? 5'(clamp(next_link[cur])) : 5'd0;
        taken[idx] = 1'b1;
        dir_name[dc] = it.file_name;
        dir_index[dc] = 4'(idx);
        owe(STS_OK, idx, 1, dc, 1);
        dir_count++;
        return;
      end
      if (slot >= dc || slot >= MAX_FILES_DEF) begin
        owe(STS_NO_FILE, 0, 0, 0, 1);
        return;
      end
      // Walk the file's chain, then splice it in front of the free head.
      cur = clamp(dir_first[slot]);
      n = 1;
      taken[cur] = 1'b0;
      while (cur != clamp(dir_last[slot]) && n < NUM_BLOCKS_DEF) begin
        cur = clamp(next_link[cur]);
        taken[cur] = 1'b0;
        n++;
      end
      next_link[cur] = (free_count != 0) ? free_head : 5'd0;
      free_head = 5'(clamp(dir_first[slot]));
      total = free_count + n;
      free_count = 5'((total > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : total);
      idx = clamp(dir_index[slot]);
      taken[idx] = 1'b0;
      for (int k = slot; k + 1 < dc; k++) begin
        dir_name[k] = dir_name[k + 1];
        dir_index[k] = dir_index[k + 1];
        dir_first[k] = dir_first[k + 1];
        dir_last[k] = dir_last[k + 1];
      end
      dir_count--;
      owe(STS_OK, idx, 1, slot, 1);
    endfunction

    function void match_result(out_item_t got);
      out_item_t want;
      if (owed_results.size() == 0) begin
        if (errors < 10)
          $display("%0t: unexpected result sts=%0d blk=%0d idx=%0b slot=%0d last=%0b",
                   $realtime, got.status, got.block_number, got.is_index,
                   got.dir_slot, got.last);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (got.status !== want.status || got.block_number !== want.block_number ||
          got.is_index !== want.is_index || got.dir_slot !== want.dir_slot ||
          got.last !== want.last) begin
        if (errors < 10)
          $display("%0t: MISCOMPARE exp sts=%0d blk=%0d idx=%0b slot=%0d last=%0b,",
                   $realtime, want.status, want.block_number, want.is_index,
                   want.dir_slot, want.last,
                   " got sts=%0d blk=%0d idx=%0b slot=%0d last=%0b",
                   got.status, got.block_number, got.is_index, got.dir_slot,
                   got.last);
        errors++;
      end
    endfunction
  endclass

endpackage

// File: tb/sv/tb.sv
// Testbench top for the indexed block allocator: stimulus, result monitor and verdict.
`timescale 1ns / 1ps
module tb;
  import iba_pkg::*;
  import iba_tb_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  free_list_tracker tracker;
  bit               idle_on;

  indexed_block_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 8 ns period, low then high.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result beats last one cycle and cannot be stalled: take every one at the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      tracker.match_result(out_item);
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2_000_000;
    $display("indexed_block_allocator: mismatch");
    $finish;
  end

  function automatic in_item_t make_cmd(cmd_t c, int name, int size, int slot);
    in_item_t it;
    it.cmd = c;
    it.file_name = 8'(name);
    it.file_size = 5'(size);
    it.file_slot = 4'(slot);
    return it;
  endfunction

  // Called and left at a falling edge. Start stays high after the beat so a
  // back-to-back command can follow without a gap; callers drop it when they stop.
  task automatic send_beat(in_item_t it);
    if (idle_on) begin
      while ($urandom_range(99) < 18) begin
        start = 1'b0;
        @(negedge clk);
      end
    end
    start = 1'b1;
    in_item = it;
    do @(posedge clk); while (busy);
    tracker.apply_command(it);
    @(negedge clk);
  endtask

  // Unused fields get random content so their bits still toggle.
  task automatic alloc(int name, int size);
    send_beat(make_cmd(CMD_ALLOC, name, size, $urandom_range(0, 9)));
  endtask

  task automatic remove(int slot);
    send_beat(make_cmd(CMD_DELETE, $urandom_range(0, 255), $urandom_range(0, 16), slot));
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (tracker.owed_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Mask writes only with the block quiet: all beats in, delete compaction
  // finished (runs after its result), and no rebuild in progress.
  task automatic write_mask(logic [15:0] m);
    drain_results();
    repeat (40) @(negedge clk);
    while (busy) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = m;
    @(posedge clk);
    tracker.load_mask(m);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly well-formed traffic: deletes of live slots and allocations that
  // fit the free chain, small sizes favored; about a tenth is raw noise.
  function automatic in_item_t pick_cmd();
    int r, dc, fc, hi;
    r = $urandom_range(99);
    dc = tracker.dir_count;
    fc = tracker.free_count;
    if (r < 10)
      return make_cmd(cmd_t'($urandom_range(0, 1)), $urandom_range(0, 255),
                      $urandom_range(0, 16), $urandom_range(0, 9));
    if (dc > 0 && (r < 50 || fc == 0))
      return make_cmd(CMD_DELETE, $urandom_range(0, 255), $urandom_range(0, 16),
                      $urandom_range(0, dc - 1));
    hi = (fc == 0) ? 3 : ((fc > 16) ? 16 : fc);
    if ($urandom_range(3) != 0 && hi > 4) hi = 4;
    return make_cmd(CMD_ALLOC, $urandom_range(0, 255), $urandom_range(1, hi),
                    $urandom_range(0, 9));
  endfunction

  function automatic logic [15:0] random_mask();
    logic [15:0] m;
    m = '0;
    repeat ($urandom_range(1, 5)) m[$urandom_range(0, 15)] = 1'b1;
    return m;
  endfunction

  initial begin
    logic [15:0] phase_mask;
    tracker = new();
    idle_on = 1'b1;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    tracker.load_mask(MASK_RESET);

    // Reset mask: index blocks 2, 8, 11, thirteen data blocks.
    alloc(8'h00, 0);            // zero size
    alloc(8'h11, 31);           // size above the per-file limit
    alloc(8'h22, 14);           // one more than the free chain holds
    remove(0);                  // empty directory
    remove(15);                 // slot far out of range
    alloc(8'h00, 1);
    alloc(8'hFF, 16);           // no space left for it
    alloc(8'hA5, 4);
    alloc(8'h5A, 7);            // takes the last index block
    alloc(8'h33, 1);            // data left but no index block
    remove(1);                  // middle slot, directory compacts
    alloc(8'h44, 1);            // reuses the freed index block
    remove(2);                  // last slot
    remove(0);
    remove(0);
    remove(0);                  // directory already empty
    alloc(8'h77, 13);           // drains the free chain to zero
    remove(0);                  // splice onto an empty free chain

    write_mask(16'h8000);       // one index block, fifteen data blocks
    alloc(8'h99, 15);
    alloc(8'h12, 1);
    remove(0);

    write_mask(16'h0000);       // no index blocks at all
    alloc(8'h34, 16);

    write_mask(16'hFFFF);       // no data blocks at all
    alloc(8'h56, 1);
    remove(0);

    // Random phases, each under its own mask; phase 2 runs without idling.
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: phase_mask = MASK_RESET;
        1: phase_mask = 16'h8001;
        5: phase_mask = 16'h0003;
        default: phase_mask = random_mask();
      endcase
      write_mask(phase_mask);
      idle_on = (p != 2);
      for (int i = 0; i < 40; i++) begin
        if (p == 3 && i == 20) drain_results();   // sender holds until all beats are back
        send_beat(pick_cmd());
      end
    end
    idle_on = 1'b1;

    drain_results();
    repeat (40) @(posedge clk);
    if (tracker.errors == 0 && tracker.owed_results.size() == 0) begin
      $display("indexed_block_allocator: match");
    end else begin
      $display("indexed_block_allocator: mismatch");
    end
    $finish;
  end

endmodule
